[rtl/markup_entity_codec_defines.svh]
// Assertion macros shared by the markup entity codec RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MARKUP_ENTITY_CODEC_DEFINES_SVH
`define MARKUP_ENTITY_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
`define MEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MEC_ASSERT(lbl, prop, msg)
`define MEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/mec_pkg.sv]
// Types, constants and entity tables of the markup entity codec.
// No dependencies; imported by every module of the codec.
package mec_pkg;

  localparam int unsigned HOLD_MAX  = 5;
  localparam int unsigned SEQ_MAX   = 6;
  localparam int unsigned ENT_NUM   = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned ENT_AMP  = 0;
  localparam int unsigned ENT_LT   = 1;
  localparam int unsigned ENT_GT   = 2;
  localparam int unsigned ENT_QUOT = 3;
  localparam int unsigned ENT_APOS = 4;

  typedef enum logic {
    REG_DIRECTION = 1'b0,
    REG_DIALECT   = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    DIR_ESCAPE   = 1'b0,
    DIR_UNESCAPE = 1'b1
  } dir_e;

  typedef enum logic {
    DIALECT_HTML = 1'b0,
    DIALECT_XML  = 1'b1
  } dialect_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // Byte 0 is the leftmost character.
  typedef logic [0:SEQ_MAX-1][7:0] seq_t;

  typedef struct packed {
    seq_t             bytes;
    logic [CNT_W-1:0] count;
  } seq_run_t;

  // One queued job: a run of output bytes caused by one input beat.
  typedef struct packed {
    seq_run_t run;
    logic     last;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       prefix;
    logic [7:0] val;
  } match_t;

  localparam seq_t ENT_TXT [ENT_NUM] = '{
    {"&amp;", 8'h00},
    {"&lt;", 16'h0000},
    {"&gt;", 16'h0000},
    "&quot;",
    "&apos;",
    "&nbsp;",
    {"&#39;", 8'h00}
  };

  localparam logic [CNT_W-1:0] ENT_LEN [ENT_NUM] = '{
    3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd5
  };

  localparam logic [7:0] ENT_VAL [ENT_NUM] = '{
    CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SPACE, CH_APOS
  };

  // Bit e set means entity e belongs to the dialect.
  localparam logic [ENT_NUM-1:0] ENT_IN_HTML = 7'b0111111;
  localparam logic [ENT_NUM-1:0] ENT_IN_XML  = 7'b1011111;

  function automatic seq_run_t esc_expand(logic [7:0] b, logic xml);
    seq_run_t r;
    r          = '0;
    r.bytes[0] = b;
    r.count    = 3'd1;
    unique case (b)
      CH_AMP: begin
        r.bytes = ENT_TXT[ENT_AMP];
        r.count = ENT_LEN[ENT_AMP];
      end
      CH_LT: begin
        r.bytes = ENT_TXT[ENT_LT];
        r.count = ENT_LEN[ENT_LT];
      end
      CH_GT: begin
        r.bytes = ENT_TXT[ENT_GT];
        r.count = ENT_LEN[ENT_GT];
      end
      CH_QUOT: begin
        r.bytes = ENT_TXT[ENT_QUOT];
        r.count = ENT_LEN[ENT_QUOT];
      end
      CH_APOS: begin
        if (xml) begin
          r.bytes = ENT_TXT[ENT_APOS];
          r.count = ENT_LEN[ENT_APOS];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compares the first n bytes of win with every entity of the dialect.
  function automatic match_t ent_classify(seq_t win, logic [CNT_W-1:0] n, logic xml);
    match_t             m;
    logic [ENT_NUM-1:0] en;
    logic               same;
    m  = '0;
    en = xml ? ENT_IN_XML : ENT_IN_HTML;
    for (int e = 0; e < ENT_NUM; e++) begin
      same = 1'b1;
      for (int i = 0; i < SEQ_MAX; i++) begin
        if (i < int'(n) && win[i] != ENT_TXT[e][i]) begin
          same = 1'b0;
        end
      end
      if (en[e] && same && n <= ENT_LEN[e]) begin
        if (n == ENT_LEN[e]) begin
          m.full = 1'b1;
          m.val  = ENT_VAL[e];
        end else begin
          m.prefix = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

[rtl/mec_front.sv]
// Front end of the codec: accepts input beats, holds entity prefixes and
// turns the other accepted beats into jobs of output bytes. Depends on mec_pkg.
`include "markup_entity_codec_defines.svh"

module mec_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  mec_pkg::cfg_reg_e cfg_idx_i,
  input  logic              cfg_data_i,
  input  logic              accept_i,
  input  mec_pkg::in_item_t in_data_i,
  output logic              push_o,
  output mec_pkg::job_t     job_o
);
  import mec_pkg::*;

  dir_e             dir_q, dir_d;
  dialect_e         dialect_q, dialect_d;
  logic [CNT_W-1:0] hold_cnt_q, hold_cnt_d;
  logic [7:0]       hold_q [HOLD_MAX];
  logic [7:0]       hold_d [HOLD_MAX];

  seq_t             buf_s;
  logic [CNT_W-1:0] n_s;
  match_t           m_s;
  seq_run_t         esc_s;
  logic             last_s;

  always_comb begin
    dir_d     = dir_q;
    dialect_d = dialect_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIRECTION: dir_d     = dir_e'(cfg_data_i);
        REG_DIALECT:   dialect_d = dialect_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The held bytes followed by the new byte, oldest first.
  always_comb begin
    buf_s = '0;
    for (int i = 0; i < HOLD_MAX; i++) begin
      buf_s[i] = (i < int'(hold_cnt_q)) ? hold_q[i] : 8'h00;
    end
    buf_s[hold_cnt_q] = in_data_i.in_byte;
  end

  assign n_s    = hold_cnt_q + 3'd1;
  assign last_s = in_data_i.in_last;
  assign m_s    = ent_classify(buf_s, n_s, dialect_q == DIALECT_XML);
  assign esc_s  = esc_expand(in_data_i.in_byte, dialect_q == DIALECT_XML);

  always_comb begin
    job_o      = '0;
    job_o.last = last_s;
    push_o     = 1'b0;
    hold_cnt_d = hold_cnt_q;
    for (int i = 0; i < HOLD_MAX; i++) begin
      hold_d[i] = hold_q[i];
    end
    if (cfg_we_i) begin
      // A register write drops whatever is held without emitting it.
      hold_cnt_d = '0;
    end else if (accept_i) begin
      if (dir_q == DIR_ESCAPE) begin
        job_o.run = esc_s;
        push_o    = 1'b1;
      end else if (m_s.full) begin
        job_o.run.bytes[0] = m_s.val;
        job_o.run.count    = 3'd1;
        push_o             = 1'b1;
        hold_cnt_d         = '0;
      end else if (m_s.prefix && !last_s) begin
        hold_cnt_d = n_s;
        for (int i = 0; i < HOLD_MAX; i++) begin
          hold_d[i] = buf_s[i];
        end
      end else if (hold_cnt_q != '0 && in_data_i.in_byte == CH_AMP && !last_s) begin
        // The held bytes after the leading ampersand hold no ampersand, so a
        // failed prefix is emitted as is and a new ampersand starts over.
        job_o.run.bytes = buf_s;
        job_o.run.count = hold_cnt_q;
        push_o          = 1'b1;
        hold_cnt_d      = 3'd1;
        hold_d[0]       = CH_AMP;
      end else begin
        job_o.run.bytes = buf_s;
        job_o.run.count = n_s;
        push_o          = 1'b1;
        hold_cnt_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DIR_ESCAPE;
      dialect_q  <= DIALECT_XML;
      hold_cnt_q <= '0;
    end else begin
      dir_q      <= dir_d;
      dialect_q  <= dialect_d;
      hold_cnt_q <= hold_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HOLD_MAX; i++) begin
      hold_q[i] <= hold_d[i];
    end
  end

  `MEC_ASSERT(a_hold_starts_amp, hold_cnt_q != '0 |-> hold_q[0] == CH_AMP, "held run lost its ampersand")
  `MEC_ASSERT(a_cfg_clears_hold, cfg_we_i |=> hold_cnt_q == '0, "register write left bytes held")

endmodule

[rtl/mec_queue.sv]
// Short job queue that decouples the front end from the output side.
// Depends on mec_pkg.
`include "markup_entity_codec_defines.svh"

module mec_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mec_pkg::job_t push_data_i,
  input  logic          pop_i,
  output mec_pkg::job_t head_o,
  output logic          valid_o,
  output logic          full_o
);
  import mec_pkg::*;

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `MEC_ASSERT(a_no_push_full, push_i |-> !full_o || pop_i, "job pushed into a full queue")

endmodule

[rtl/mec_emit.sv]
// Output side of the codec: walks the job at the head of the queue and
// sends one byte per beat through an output register. Depends on mec_pkg.
`include "markup_entity_codec_defines.svh"

module mec_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mec_pkg::job_t      head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output mec_pkg::out_item_t out_data_o
);
  import mec_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             load_s;
  logic             take_s;
  logic             run_end_s;

  // The output register can take a byte when empty or being drained.
  assign load_s    = !out_valid_q || !out_stall_i;
  assign take_s    = load_s && head_valid_i;
  assign run_end_s = idx_q == CNT_W'(head_i.run.count - 3'd1);
  assign pop_o     = take_s && run_end_s;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = load_s ? head_valid_i : out_valid_q;
    out_d       = out_q;
    if (take_s) begin
      idx_d            = run_end_s ? '0 : idx_q + 3'd1;
      out_d.out_byte   = head_i.run.bytes[idx_q];
      out_d.run_last   = run_end_s;
      out_d.string_end = run_end_s && head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MEC_ASSERT(a_idx_in_run, head_valid_i |-> idx_q < head_i.run.count, "byte index past end of run")
  `MEC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

[rtl/markup_entity_codec.sv]
// Top level of the markup entity codec: front end, job queue and output side.
// Depends on mec_pkg, mec_front, mec_queue and mec_emit.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A beat is classified in the cycle it is accepted; its job is registered in the
// queue, and its bytes go from the queue head to the output register, one byte
// per cycle while out_stall_i is low. A job stays at the queue head until its
// last byte is loaded; an escape that yields an entity holds the output side for each byte.
// The two-entry job queue sets when in_stall_o rises; stalls on the output
// hold the queue and, once it is full, the input.
// Reset is asynchronous and clears all control state; no clearing pass follows.
`include "markup_entity_codec_defines.svh"

module markup_entity_codec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  mec_pkg::cfg_reg_e  cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mec_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mec_pkg::out_item_t out_data_o
);
  import mec_pkg::*;

  logic accept_s;
  logic push_s;
  job_t job_s;
  job_t head_s;
  logic head_valid_s;
  logic full_s;
  logic pop_s;

  assign in_stall_o = full_s;
  assign accept_s   = in_valid_i && !full_s;

  mec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept_s),
    .in_data_i  (in_data_i),
    .push_o     (push_s),
    .job_o      (job_s)
  );

  mec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_s),
    .push_data_i (job_s),
    .pop_i       (pop_s),
    .head_o      (head_s),
    .valid_o     (head_valid_s),
    .full_o      (full_s)
  );

  mec_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_s),
    .head_valid_i (head_valid_s),
    .pop_o        (pop_s),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  `MEC_ASSERT(a_stall_when_full, full_s |-> in_stall_o, "input taken while the queue is full")

endmodule
